// ===== hdl/gcf_pkg.sv =====
// Shared types, codes and the arithmetic step program of the gammatone channel filter.
package gcf_pkg;

  localparam int V_W    = 64;
  localparam int C_W    = 48;
  localparam int PROD_W = V_W + C_W;
  localparam int ACC_W  = 120;
  localparam int OSC_W  = 32;
  localparam int DIG_W  = 16;
  localparam int NUM_DIGITS = C_W / DIG_W;
  localparam int NUM_STEPS  = 26;
  localparam int STEP_W = 5;

  localparam logic [2:0] CFG_DECAY     = 3'd0;
  localparam logic [2:0] CFG_COS_STEP  = 3'd1;
  localparam logic [2:0] CFG_SIN_STEP  = 3'd2;
  localparam logic [2:0] CFG_GAIN      = 3'd3;
  localparam logic [2:0] CFG_HALF_RECT = 3'd4;

  localparam logic [4:0] V_X    = 5'd0;
  localparam logic [4:0] V_HR0  = 5'd1;
  localparam logic [4:0] V_HR1  = 5'd2;
  localparam logic [4:0] V_HR2  = 5'd3;
  localparam logic [4:0] V_HR3  = 5'd4;
  localparam logic [4:0] V_HI0  = 5'd5;
  localparam logic [4:0] V_HI1  = 5'd6;
  localparam logic [4:0] V_HI2  = 5'd7;
  localparam logic [4:0] V_HI3  = 5'd8;
  localparam logic [4:0] V_P0R  = 5'd9;
  localparam logic [4:0] V_P0I  = 5'd10;
  localparam logic [4:0] V_U0R  = 5'd11;
  localparam logic [4:0] V_U0I  = 5'd12;
  localparam logic [4:0] V_PROJ = 5'd13;
  localparam logic [4:0] V_CS   = 5'd14;
  localparam logic [4:0] V_SS   = 5'd15;
  localparam logic [4:0] V_A    = 5'd16;
  localparam logic [4:0] V_A2   = 5'd17;
  localparam logic [4:0] V_A3   = 5'd18;

  localparam logic [3:0] C_COS  = 4'd0;
  localparam logic [3:0] C_SIN  = 4'd1;
  localparam logic [3:0] C_K1   = 4'd2;
  localparam logic [3:0] C_K2   = 4'd3;
  localparam logic [3:0] C_K3   = 4'd4;
  localparam logic [3:0] C_K4   = 4'd5;
  localparam logic [3:0] C_K5   = 4'd6;
  localparam logic [3:0] C_ONE  = 4'd7;
  localparam logic [3:0] C_GAIN = 4'd8;
  localparam logic [3:0] C_A    = 4'd9;

  localparam logic [2:0] SH_NONE   = 3'd0;
  localparam logic [2:0] SH_SAMPLE = 3'd1;
  localparam logic [2:0] SH_COEF   = 3'd2;
  localparam logic [2:0] SH_OSC    = 3'd3;
  localparam logic [2:0] SH_OUT    = 3'd4;

  localparam logic [3:0] D_NONE = 4'd0;
  localparam logic [3:0] D_A2   = 4'd1;
  localparam logic [3:0] D_A3   = 4'd2;
  localparam logic [3:0] D_A4   = 4'd3;
  localparam logic [3:0] D_P0R  = 4'd4;
  localparam logic [3:0] D_P0I  = 4'd5;
  localparam logic [3:0] D_U0R  = 4'd6;
  localparam logic [3:0] D_U0I  = 4'd7;
  localparam logic [3:0] D_PROJ = 4'd8;
  localparam logic [3:0] D_Y    = 4'd9;
  localparam logic [3:0] D_NC   = 4'd10;
  localparam logic [3:0] D_NS   = 4'd11;

  localparam logic [1:0] LIM_STATE = 2'd0;
  localparam logic [1:0] LIM_OSC   = 2'd1;
  localparam logic [1:0] LIM_OUT   = 2'd2;

  typedef struct packed {
    logic [4:0] vsel;
    logic [3:0] csel;
    logic [2:0] shc;
    logic       sub;
    logic       clr;
    logic [3:0] dst;
  } step_t;

  typedef struct packed {
    logic signed [V_W-1:0] v;
    logic signed [C_W:0]   c;
    logic [6:0]            sh;
    logic                  sub;
    logic                  clr;
  } mac_op_t;

  function automatic step_t mk(logic [4:0] vs, logic [3:0] cs, logic [2:0] sc, logic sb,
                               logic cl, logic [3:0] ds);
    step_t s;
    s.vsel = vs;
    s.csel = cs;
    s.shc  = sc;
    s.sub  = sb;
    s.clr  = cl;
    s.dst  = ds;
    return s;
  endfunction

  function automatic step_t step_at(logic [STEP_W-1:0] idx);
    step_t s;
    case (idx)
      5'd0:  s = mk(V_A,    C_A,    SH_COEF,   1'b0, 1'b1, D_A2);
      5'd1:  s = mk(V_A2,   C_A,    SH_COEF,   1'b0, 1'b1, D_A3);
      5'd2:  s = mk(V_A3,   C_A,    SH_COEF,   1'b0, 1'b1, D_A4);
      5'd3:  s = mk(V_X,    C_COS,  SH_SAMPLE, 1'b0, 1'b1, D_NONE);
      5'd4:  s = mk(V_HR0,  C_K1,   SH_COEF,   1'b0, 1'b0, D_NONE);
      5'd5:  s = mk(V_HR1,  C_K2,   SH_COEF,   1'b1, 1'b0, D_NONE);
      5'd6:  s = mk(V_HR2,  C_K3,   SH_COEF,   1'b0, 1'b0, D_NONE);
      5'd7:  s = mk(V_HR3,  C_K4,   SH_COEF,   1'b1, 1'b0, D_P0R);
      5'd8:  s = mk(V_X,    C_SIN,  SH_SAMPLE, 1'b0, 1'b1, D_NONE);
      5'd9:  s = mk(V_HI0,  C_K1,   SH_COEF,   1'b0, 1'b0, D_NONE);
      5'd10: s = mk(V_HI1,  C_K2,   SH_COEF,   1'b1, 1'b0, D_NONE);
      5'd11: s = mk(V_HI2,  C_K3,   SH_COEF,   1'b0, 1'b0, D_NONE);
      5'd12: s = mk(V_HI3,  C_K4,   SH_COEF,   1'b1, 1'b0, D_P0I);
      5'd13: s = mk(V_P0R,  C_ONE,  SH_NONE,   1'b0, 1'b1, D_NONE);
      5'd14: s = mk(V_HR0,  C_K1,   SH_COEF,   1'b0, 1'b0, D_NONE);
      5'd15: s = mk(V_HR1,  C_K5,   SH_COEF,   1'b0, 1'b0, D_U0R);
      5'd16: s = mk(V_P0I,  C_ONE,  SH_NONE,   1'b0, 1'b1, D_NONE);
      5'd17: s = mk(V_HI0,  C_K1,   SH_COEF,   1'b0, 1'b0, D_NONE);
      5'd18: s = mk(V_HI1,  C_K5,   SH_COEF,   1'b0, 1'b0, D_U0I);
      5'd19: s = mk(V_U0R,  C_COS,  SH_OSC,    1'b0, 1'b1, D_NONE);
      5'd20: s = mk(V_U0I,  C_SIN,  SH_OSC,    1'b0, 1'b0, D_PROJ);
      5'd21: s = mk(V_PROJ, C_GAIN, SH_OUT,    1'b0, 1'b1, D_Y);
      5'd22: s = mk(V_CS,   C_COS,  SH_OSC,    1'b0, 1'b1, D_NONE);
      5'd23: s = mk(V_SS,   C_SIN,  SH_OSC,    1'b0, 1'b0, D_NC);
      5'd24: s = mk(V_CS,   C_SIN,  SH_OSC,    1'b0, 1'b1, D_NONE);
      5'd25: s = mk(V_SS,   C_COS,  SH_OSC,    1'b1, 1'b0, D_NS);
      default: s = mk(V_X,  C_ONE,  SH_NONE,   1'b0, 1'b1, D_NONE);
    endcase
    return s;
  endfunction

endpackage

// ===== hdl/gcf_mac.sv =====
// Shared multiply-accumulate unit: digit-serial product, rounding shift, wide accumulator.
module gcf_mac #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int STATE_WIDTH  = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  gcf_pkg::mac_op_t             op,
  input  logic [1:0]                   lim_sel,
  output logic                         done,
  output logic signed [gcf_pkg::V_W-1:0] sat_val
);

  localparam int AW = gcf_pkg::ACC_W;
  localparam int PW = gcf_pkg::PROD_W;
  localparam logic signed [AW-1:0] ST_MAX =
    {{(AW-STATE_WIDTH+1){1'b0}}, {(STATE_WIDTH-1){1'b1}}};
  localparam logic signed [AW-1:0] OSC_MAX =
    {{(AW-gcf_pkg::OSC_W+1){1'b0}}, {(gcf_pkg::OSC_W-1){1'b1}}};
  localparam logic signed [AW-1:0] OUT_MAX =
    {{(AW-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};

  logic                       busy_r;
  logic [1:0]                 ph_r;
  logic                       done_r;
  logic [gcf_pkg::V_W-1:0]    mv_r;
  logic [gcf_pkg::C_W-1:0]    mc_r;
  logic                       neg_r;
  logic [6:0]                 sh_r;
  logic                       clr_r;
  logic [PW-1:0]              prod_r;
  logic signed [AW-1:0]       acc_r;

  logic [gcf_pkg::V_W-1:0]    mag_v;
  logic [gcf_pkg::C_W:0]      mag_c;
  logic [gcf_pkg::DIG_W-1:0]  digit;
  logic [PW-1:0]              pp;
  logic [PW-1:0]              half;
  logic [PW:0]                rsum;
  logic [PW:0]                rounded;
  logic signed [AW-1:0]       term;
  logic signed [AW-1:0]       acc_base;
  logic signed [AW-1:0]       acc_nxt;
  logic signed [AW-1:0]       hi_lim;
  logic signed [AW-1:0]       lo_lim;
  logic signed [AW-1:0]       sat_full;

  always_comb begin
    mag_v = op.v[gcf_pkg::V_W-1] ? (gcf_pkg::V_W'(0) - op.v) : op.v;
    mag_c = op.c[gcf_pkg::C_W] ? ((gcf_pkg::C_W+1)'(0) - op.c) : op.c;
    case (ph_r)
      2'd0:    digit = mc_r[15:0];
      2'd1:    digit = mc_r[31:16];
      default: digit = mc_r[47:32];
    endcase
    pp = (PW'(mv_r) * PW'(digit)) << {ph_r, 4'b0000};
    half = (sh_r == 7'd0) ? '0 : (PW'(1) << (sh_r - 7'd1));
    rsum = (PW+1)'(prod_r) + (PW+1)'(half);
    rounded = rsum >> sh_r;
    term = $signed({{(AW-PW-1){1'b0}}, rounded});
    acc_base = clr_r ? '0 : acc_r;
    acc_nxt = neg_r ? (acc_base - term) : (acc_base + term);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ph_r   <= 2'd0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r) begin
        if (start) begin
          busy_r <= 1'b1;
          ph_r   <= 2'd0;
          mv_r   <= mag_v;
          mc_r   <= mag_c[gcf_pkg::C_W-1:0];
          neg_r  <= ((op.v < 0) != (op.c < 0)) != op.sub;
          sh_r   <= op.sh;
          clr_r  <= op.clr;
        end
      end else if (ph_r != 2'(gcf_pkg::NUM_DIGITS)) begin
        prod_r <= (ph_r == 2'd0) ? pp : (prod_r + pp);
        ph_r   <= ph_r + 2'd1;
      end else begin
        acc_r  <= acc_nxt;
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_comb begin
    case (lim_sel)
      gcf_pkg::LIM_OSC: begin
        hi_lim = OSC_MAX;
        lo_lim = -OSC_MAX;
      end
      gcf_pkg::LIM_OUT: begin
        hi_lim = OUT_MAX;
        lo_lim = ~OUT_MAX;
      end
      default: begin
        hi_lim = ST_MAX;
        lo_lim = -ST_MAX;
      end
    endcase
    if (acc_r > hi_lim) begin
      sat_full = hi_lim;
    end else if (acc_r < lo_lim) begin
      sat_full = lo_lim;
    end else begin
      sat_full = acc_r;
    end
  end

  assign sat_val = sat_full[gcf_pkg::V_W-1:0];
  assign done    = done_r;

endmodule

// ===== hdl/gammatone_channel_filter_top.sv =====
// Top level of one gammatone channel filter with its step sequencer and state registers.
//
// The input channel (in_valid, in_stall, in_sample, in_frame_start) takes one audio
// sample per transaction; in_frame_start clears the filter history and resets the
// oscillator before that sample is used. The result channel (out_valid, out_stall,
// out_filtered) returns exactly one filtered sample per input transaction.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes decay,
// cos_step, sin_step, gain and half_rect; cfg_ready is high only while the block is idle.
// Every sample runs 26 multiply-accumulate steps through one shared 64 x 16 bit
// multiplier, three digits per product followed by rounding and accumulation, under
// the step sequencer. in_stall stays high from the accepted input transaction until
// the result is written to the output register, so a new sample is accepted only
// once the previous one has left the sequencer.
// The result is held in an output register; a new sample is accepted while it waits,
// and the final update waits only while a held result is still stalled.
// Reset clears the configuration to its defaults, the history to zero and the
// oscillator to cos = 1.0, sin = 0.
module gammatone_channel_filter_top #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int STATE_WIDTH  = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  input  logic                           in_frame_start,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] out_filtered,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [2:0]                     cfg_index,
  input  logic [47:0]                    cfg_data
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;
  localparam int VW = gcf_pkg::V_W;
  localparam int CW = gcf_pkg::C_W + 1;
  localparam logic signed [31:0] OSC_ONE = 32'sh4000_0000;

  logic [1:0]                    state_r;
  logic [gcf_pkg::STEP_W-1:0]    step_r;
  logic [23:0]                   decay_r;
  logic signed [31:0]            cos_step_r;
  logic signed [31:0]            sin_step_r;
  logic [47:0]                   gain_r;
  logic                          half_rect_r;
  logic [24:0]                   a2_r;
  logic [24:0]                   a3_r;
  logic [24:0]                   a4_r;
  logic signed [STATE_WIDTH-1:0] hist_re_r [4];
  logic signed [STATE_WIDTH-1:0] hist_im_r [4];
  logic signed [31:0]            osc_cos_r;
  logic signed [31:0]            osc_sin_r;
  logic signed [SAMPLE_WIDTH-1:0] x_r;
  logic signed [STATE_WIDTH-1:0] p0r_r;
  logic signed [STATE_WIDTH-1:0] p0i_r;
  logic signed [STATE_WIDTH-1:0] u0r_r;
  logic signed [STATE_WIDTH-1:0] u0i_r;
  logic signed [STATE_WIDTH-1:0] proj_r;
  logic signed [31:0]            nc_r;
  logic signed [31:0]            ns_r;
  logic signed [SAMPLE_WIDTH-1:0] y_r;
  logic                          out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] out_filtered_r;

  gcf_pkg::step_t                step;
  gcf_pkg::mac_op_t              mac_op;
  logic [1:0]                    lim_sel;
  logic                          mac_done;
  logic signed [VW-1:0]          sat_val;
  logic signed [SAMPLE_WIDTH-1:0] y_sat;
  logic                          in_accept;
  logic                          out_free;

  assign step      = gcf_pkg::step_at(step_r);
  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = (state_r == S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_filtered = out_filtered_r;

  always_comb begin
    case (step.vsel)
      gcf_pkg::V_X:    mac_op.v = VW'(x_r);
      gcf_pkg::V_HR0:  mac_op.v = VW'(hist_re_r[0]);
      gcf_pkg::V_HR1:  mac_op.v = VW'(hist_re_r[1]);
      gcf_pkg::V_HR2:  mac_op.v = VW'(hist_re_r[2]);
      gcf_pkg::V_HR3:  mac_op.v = VW'(hist_re_r[3]);
      gcf_pkg::V_HI0:  mac_op.v = VW'(hist_im_r[0]);
      gcf_pkg::V_HI1:  mac_op.v = VW'(hist_im_r[1]);
      gcf_pkg::V_HI2:  mac_op.v = VW'(hist_im_r[2]);
      gcf_pkg::V_HI3:  mac_op.v = VW'(hist_im_r[3]);
      gcf_pkg::V_P0R:  mac_op.v = VW'(p0r_r);
      gcf_pkg::V_P0I:  mac_op.v = VW'(p0i_r);
      gcf_pkg::V_U0R:  mac_op.v = VW'(u0r_r);
      gcf_pkg::V_U0I:  mac_op.v = VW'(u0i_r);
      gcf_pkg::V_PROJ: mac_op.v = VW'(proj_r);
      gcf_pkg::V_CS:   mac_op.v = VW'(cos_step_r);
      gcf_pkg::V_SS:   mac_op.v = VW'(sin_step_r);
      gcf_pkg::V_A:    mac_op.v = $signed(VW'(decay_r));
      gcf_pkg::V_A2:   mac_op.v = $signed(VW'(a2_r));
      gcf_pkg::V_A3:   mac_op.v = $signed(VW'(a3_r));
      default:         mac_op.v = '0;
    endcase
    case (step.csel)
      gcf_pkg::C_COS:  mac_op.c = CW'(osc_cos_r);
      gcf_pkg::C_SIN:  mac_op.c = CW'(osc_sin_r);
      gcf_pkg::C_K1:   mac_op.c = $signed(CW'({decay_r, 2'b00}));
      gcf_pkg::C_K2:   mac_op.c = $signed(CW'(28'(a2_r) * 28'd6));
      gcf_pkg::C_K3:   mac_op.c = $signed(CW'({a3_r, 2'b00}));
      gcf_pkg::C_K4:   mac_op.c = $signed(CW'(a4_r));
      gcf_pkg::C_K5:   mac_op.c = $signed(CW'(a2_r));
      gcf_pkg::C_ONE:  mac_op.c = CW'(1);
      gcf_pkg::C_GAIN: mac_op.c = $signed(CW'(gain_r));
      gcf_pkg::C_A:    mac_op.c = $signed(CW'(decay_r));
      default:         mac_op.c = '0;
    endcase
    case (step.shc)
      gcf_pkg::SH_SAMPLE: mac_op.sh = 7'(SAMPLE_WIDTH - 1);
      gcf_pkg::SH_COEF:   mac_op.sh = 7'd24;
      gcf_pkg::SH_OSC:    mac_op.sh = 7'd30;
      gcf_pkg::SH_OUT:    mac_op.sh = 7'(78 - (SAMPLE_WIDTH - 1));
      default:            mac_op.sh = 7'd0;
    endcase
    mac_op.sub = step.sub;
    mac_op.clr = step.clr;
    case (step.dst)
      gcf_pkg::D_NC, gcf_pkg::D_NS: lim_sel = gcf_pkg::LIM_OSC;
      gcf_pkg::D_Y:                 lim_sel = gcf_pkg::LIM_OUT;
      default:                      lim_sel = gcf_pkg::LIM_STATE;
    endcase
    y_sat = sat_val[SAMPLE_WIDTH-1:0];
    if (half_rect_r && y_sat < 0) begin
      y_sat = '0;
    end
  end

  gcf_mac #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .STATE_WIDTH (STATE_WIDTH)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (state_r == S_ISSUE),
    .op     (mac_op),
    .lim_sel(lim_sel),
    .done   (mac_done),
    .sat_val(sat_val)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      decay_r     <= '0;
      cos_step_r  <= OSC_ONE;
      sin_step_r  <= '0;
      gain_r      <= '0;
      half_rect_r <= 1'b0;
      osc_cos_r   <= OSC_ONE;
      osc_sin_r   <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        hist_re_r[i] <= '0;
        hist_im_r[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          gcf_pkg::CFG_DECAY:     decay_r     <= cfg_data[23:0];
          gcf_pkg::CFG_COS_STEP:  cos_step_r  <= $signed(cfg_data[31:0]);
          gcf_pkg::CFG_SIN_STEP:  sin_step_r  <= $signed(cfg_data[31:0]);
          gcf_pkg::CFG_GAIN:      gain_r      <= cfg_data;
          gcf_pkg::CFG_HALF_RECT: half_rect_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            x_r     <= in_sample;
            step_r  <= '0;
            state_r <= S_ISSUE;
            if (in_frame_start) begin
              osc_cos_r <= OSC_ONE;
              osc_sin_r <= '0;
              for (int i = 0; i < 4; i++) begin
                hist_re_r[i] <= '0;
                hist_im_r[i] <= '0;
              end
            end
          end
        end
        S_ISSUE: begin
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (mac_done) begin
            case (step.dst)
              gcf_pkg::D_A2:   a2_r   <= sat_val[24:0];
              gcf_pkg::D_A3:   a3_r   <= sat_val[24:0];
              gcf_pkg::D_A4:   a4_r   <= sat_val[24:0];
              gcf_pkg::D_P0R:  p0r_r  <= sat_val[STATE_WIDTH-1:0];
              gcf_pkg::D_P0I:  p0i_r  <= sat_val[STATE_WIDTH-1:0];
              gcf_pkg::D_U0R:  u0r_r  <= sat_val[STATE_WIDTH-1:0];
              gcf_pkg::D_U0I:  u0i_r  <= sat_val[STATE_WIDTH-1:0];
              gcf_pkg::D_PROJ: proj_r <= sat_val[STATE_WIDTH-1:0];
              gcf_pkg::D_Y:    y_r    <= y_sat;
              gcf_pkg::D_NC:   nc_r   <= sat_val[31:0];
              gcf_pkg::D_NS:   ns_r   <= sat_val[31:0];
              default: ;
            endcase
            if (step_r == gcf_pkg::STEP_W'(gcf_pkg::NUM_STEPS - 1)) begin
              state_r <= S_DONE;
            end else begin
              step_r  <= step_r + 1'b1;
              state_r <= S_ISSUE;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_filtered_r <= y_r;
            osc_cos_r      <= nc_r;
            osc_sin_r      <= ns_r;
            for (int i = 3; i > 0; i--) begin
              hist_re_r[i] <= hist_re_r[i-1];
              hist_im_r[i] <= hist_im_r[i-1];
            end
            hist_re_r[0] <= p0r_r;
            hist_im_r[0] <= p0i_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/gcf_checker.sv =====
// Port-level assertion checker for the gammatone channel filter and its bind statement.
module gcf_checker #(
  parameter int SAMPLE_WIDTH = 16
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [SAMPLE_WIDTH-1:0] out_filtered
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("A stalled result transaction was dropped.");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_filtered))
    else $error("A stalled result changed its payload.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("The block accepted a sample without becoming busy.");

  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("A result appeared without a sample in progress.");

endmodule

bind gammatone_channel_filter_top gcf_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_gcf_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_filtered(out_filtered)
);

// ===== bench/tb_gammatone_channel_filter_top.sv =====
// Self-checking testbench for the gammatone channel filter: directed and random samples.
module tb_gammatone_channel_filter_top;

  typedef logic signed [129:0] wide_acc_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] in_sample;
  logic               in_frame_start;
  logic               out_valid;
  logic               out_stall;
  logic signed [15:0] out_filtered;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [47:0]        cfg_data;

  gammatone_channel_filter_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_sample(in_sample),
    .in_frame_start(in_frame_start),
    .out_valid(out_valid), .out_stall(out_stall), .out_filtered(out_filtered),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  localparam logic signed [63:0] OSC_UNITY = 64'sd1073741824;

  logic [23:0]        m_decay;
  logic signed [63:0] m_cos_step;
  logic signed [63:0] m_sin_step;
  logic [47:0]        m_gain;
  logic               m_half_rect;
  logic signed [63:0] hist_re [4];
  logic signed [63:0] hist_im [4];
  logic signed [63:0] osc_re;
  logic signed [63:0] osc_im;

  logic signed [15:0] filtered_q [$];
  logic               calm;
  int                 errors;
  int                 n_results;
  int                 n_frames;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic wide_acc_t rounded_product(logic signed [63:0] v, logic signed [63:0] c,
                                                int sh);
    logic [127:0] m;
    logic [63:0]  mv;
    logic [63:0]  mc;
    mv = (v < 0) ? -v : v;
    mc = (c < 0) ? -c : c;
    m = {64'd0, mv} * {64'd0, mc};
    if (sh > 0) m = (m + (128'd1 << (sh - 1))) >> sh;
    if ((v < 0) != (c < 0)) return -$signed({2'b00, m});
    return $signed({2'b00, m});
  endfunction

  function automatic logic signed [63:0] clip(wide_acc_t a, logic [63:0] pos_lim,
                                              logic [63:0] neg_lim);
    if (a > $signed({66'd0, pos_lim})) return pos_lim;
    if (a < -$signed({66'd0, neg_lim})) return -$signed(neg_lim);
    return a[63:0];
  endfunction

  function automatic void model_reset();
    m_decay = '0;
    m_cos_step = OSC_UNITY;
    m_sin_step = '0;
    m_gain = '0;
    m_half_rect = 1'b0;
    for (int i = 0; i < 4; i++) begin
      hist_re[i] = '0;
      hist_im[i] = '0;
    end
    osc_re = OSC_UNITY;
    osc_im = '0;
  endfunction

  function automatic logic signed [15:0] filter_sample(logic signed [15:0] s, logic fs);
    logic [63:0]        a, a2, a3, a4;
    logic signed [63:0] k1, k2, k3, k4, k5, x, p0r, p0i, u0r, u0i, proj, y, nc, ns, gn;
    logic [63:0]        smax;
    logic [63:0]        omax;
    wide_acc_t          acc;
    smax = 64'h7FFF_FFFF_FFFF_FFFF;
    omax = 64'h7FFF_FFFF;
    a = {40'd0, m_decay};
    a2 = (a * a + 64'd8388608) >> 24;
    a3 = (a2 * a + 64'd8388608) >> 24;
    a4 = (a3 * a + 64'd8388608) >> 24;
    k1 = a << 2;
    k2 = a2 * 64'd6;
    k3 = a3 << 2;
    k4 = a4;
    k5 = a2;
    gn = {16'd0, m_gain};
    if (fs) begin
      for (int i = 0; i < 4; i++) begin
        hist_re[i] = '0;
        hist_im[i] = '0;
      end
      osc_re = OSC_UNITY;
      osc_im = '0;
    end
    x = s;
    acc = rounded_product(x, osc_re, 15) + rounded_product(hist_re[0], k1, 24)
        - rounded_product(hist_re[1], k2, 24) + rounded_product(hist_re[2], k3, 24)
        - rounded_product(hist_re[3], k4, 24);
    p0r = clip(acc, smax, smax);
    acc = rounded_product(x, osc_im, 15) + rounded_product(hist_im[0], k1, 24)
        - rounded_product(hist_im[1], k2, 24) + rounded_product(hist_im[2], k3, 24)
        - rounded_product(hist_im[3], k4, 24);
    p0i = clip(acc, smax, smax);
    acc = p0r + rounded_product(hist_re[0], k1, 24) + rounded_product(hist_re[1], k5, 24);
    u0r = clip(acc, smax, smax);
    acc = p0i + rounded_product(hist_im[0], k1, 24) + rounded_product(hist_im[1], k5, 24);
    u0i = clip(acc, smax, smax);
    for (int i = 3; i > 0; i--) begin
      hist_re[i] = hist_re[i - 1];
      hist_im[i] = hist_im[i - 1];
    end
    hist_re[0] = p0r;
    hist_im[0] = p0i;
    acc = rounded_product(u0r, osc_re, 30) + rounded_product(u0i, osc_im, 30);
    proj = clip(acc, smax, smax);
    acc = rounded_product(proj, gn, 63);
    y = clip(acc, 64'd32767, 64'd32768);
    if (m_half_rect && y < 0) y = '0;
    acc = rounded_product(m_cos_step, osc_re, 30) + rounded_product(m_sin_step, osc_im, 30);
    nc = clip(acc, omax, omax);
    acc = rounded_product(m_cos_step, osc_im, 30) - rounded_product(m_sin_step, osc_re, 30);
    ns = clip(acc, omax, omax);
    osc_re = nc;
    osc_im = ns;
    return y[15:0];
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (filtered_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result filtered=%0d", $time, out_filtered);
      end else begin
        if (out_filtered !== filtered_q[0]) begin
          errors++;
          $display("%0t: filtered mismatch expected %0d actual %0d", $time,
                   filtered_q[0], out_filtered);
        end
        void'(filtered_q.pop_front());
      end
    end
    out_stall <= calm ? 1'b0 : ($urandom_range(99) < 27);
  end

  task automatic send_sample(input logic signed [15:0] s, input logic fs);
    if (!calm && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    in_frame_start <= fs;
    do @(posedge clk); while (in_stall);
    if (fs) n_frames++;
    filtered_q.insert(filtered_q.size(), filter_sample(s, fs));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [47:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      gcf_pkg::CFG_DECAY:     m_decay = data[23:0];
      gcf_pkg::CFG_COS_STEP:  m_cos_step = $signed(data[31:0]);
      gcf_pkg::CFG_SIN_STEP:  m_sin_step = $signed(data[31:0]);
      gcf_pkg::CFG_GAIN:      m_gain = data;
      gcf_pkg::CFG_HALF_RECT: m_half_rect = data[0];
      default: ;
    endcase
  endtask

  task automatic set_filter(input logic [23:0] d, input logic signed [31:0] c,
                            input logic signed [31:0] s, input logic [47:0] g,
                            input logic hr);
    drain();
    write_reg(gcf_pkg::CFG_DECAY, {24'd0, d});
    write_reg(gcf_pkg::CFG_COS_STEP, {16'd0, c});
    write_reg(gcf_pkg::CFG_SIN_STEP, {16'd0, s});
    write_reg(gcf_pkg::CFG_GAIN, g);
    write_reg(gcf_pkg::CFG_HALF_RECT, {47'd0, hr});
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_sample(16'sh7FFF, 1'b0);
    send_sample(-16'sh8000, 1'b0);
    send_sample(16'sd0, 1'b1);
  endtask

  task automatic test_extremes();
    set_filter(24'hFFFFFF, 32'sh4000_0000, 32'sh0, 48'hFFFF_FFFF_FFFF, 1'b0);
    send_sample(16'sh7FFF, 1'b1);
    for (int i = 0; i < 5; i++) send_sample(16'sh7FFF, 1'b0);
    send_sample(-16'sh8000, 1'b0);
    send_sample(-16'sh8000, 1'b1);
    send_sample(-16'sh8000, 1'b0);
    set_filter(24'hF00000, 32'sh3000_0000, -32'sh2000_0000, 48'h0FFF_FFFF_FFFF, 1'b1);
    send_sample(16'sh4000, 1'b1);
    send_sample(-16'sh4000, 1'b0);
    send_sample(16'sh1234, 1'b0);
    set_filter(24'h800000, 32'sh4000_0000, 32'sh4000_0000, 48'h8000_0000_0000, 1'b0);
    for (int i = 0; i < 4; i++) send_sample(16'sh2000, 1'b0);
    set_filter(24'h0, -32'sh4000_0000, -32'sh4000_0000, 48'h1, 1'b0);
    send_sample(16'sh7FFF, 1'b1);
    send_sample(16'sh1, 1'b0);
  endtask

  task automatic test_unknown_index();
    drain();
    for (int i = gcf_pkg::CFG_HALF_RECT + 1; i < 8; i++) begin
      write_reg(i[2:0], 48'({$urandom, $urandom}));
    end
    cfg_valid <= 1'b0;
    send_sample(16'sh5555, 1'b0);
    send_sample(-16'sh2AAB, 1'b0);
  endtask

  task automatic random_setting();
    real w, r;
    logic [23:0] d;
    logic signed [31:0] c, s;
    logic [47:0] g;
    w = ($urandom_range(10000) / 10000.0) * 3.14159265;
    r = 0.5 + 0.4999 * ($urandom_range(10000) / 10000.0);
    d = 24'($rtoi(r * 16777216.0));
    c = 32'($rtoi($cos(w) * 1073741824.0));
    s = 32'($rtoi($sin(w) * 1073741824.0));
    g = 48'({$urandom, $urandom} >> $urandom_range(0, 40));
    case ($urandom_range(5))
      0: d = 24'($urandom);
      1: begin
        c = $urandom;
        s = $urandom;
      end
      2: g = 48'hFFFF_FFFF_FFFF;
      default: ;
    endcase
    set_filter(d, c, s, g, 1'($urandom_range(1)));
  endtask

  task automatic test_random_frames();
    int left;
    int frame_len;
    for (int phase = 0; phase < 6; phase++) begin
      random_setting();
      calm = (phase == 2);
      left = 300;
      while (left > 0) begin
        frame_len = $urandom_range(4, 48);
        send_sample(16'($urandom), 1'b1);
        for (int j = 1; j < frame_len && left > 0; j++) begin
          send_sample(($urandom_range(9) == 0) ? ($urandom_range(1) ? 16'sh7FFF : -16'sh8000)
                                               : 16'($urandom), $urandom_range(30) == 0);
          left--;
        end
        left--;
        if ($urandom_range(15) == 0) drain();
      end
      calm = 1'b0;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample = '0;
    in_frame_start = 1'b0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    calm = 1'b0;
    errors = 0;
    n_results = 0;
    n_frames = 0;
    model_reset();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_extremes();
    test_unknown_index();
    test_random_frames();
    drain();
    $display("Checked %0d filtered samples over %0d frames, across default, extreme and",
             n_results, n_frames);
    $display("random filter settings with stalls on both channels.");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/gcf_pkg.sv
hdl/gcf_mac.sv
hdl/gammatone_channel_filter_top.sv
hdl/gcf_checker.sv
bench/tb_gammatone_channel_filter_top.sv
